>>> rtl/core/gps_pkg.sv
// Shared constants and types for the polar Gaussian sampler.
package gps_pkg;

    // Steps of the squaring log and of the root pipelines (64-bit radicand).
    localparam int LOG_STAGES = 32;
    localparam int ISQ_STAGES = 32;

    // Quotient bits of the normalization divide (result is at most 1.0 in Q.30).
    localparam int DIV_STAGES = 31;

    // ln(2) as a 32-bit fraction.
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_MEAN_OFFSET  = 1'b0,
        REG_SCALE_FACTOR = 1'b1
    } cfg_reg_t;

endpackage

>>> rtl/core/gps_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage, with sideband.
module gps_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_value,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int N = gps_pkg::ISQ_STAGES;

    logic [N-1:0]        valid_reg;
    logic [63:0]         v_reg    [N];
    logic [63:0]         r_reg    [N];
    logic [SIDE_W-1:0]   side_reg [N];

    logic [63:0]         v_in     [N];
    logic [63:0]         r_in     [N];
    logic [63:0]         v_next   [N];
    logic [63:0]         r_next   [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [63:0] bit_k;
            logic [63:0] trial;
            if (k == 0)
            begin
                v_in[k] = in_value;
                r_in[k] = '0;
            end
            else
            begin
                v_in[k] = v_reg[k-1];
                r_in[k] = r_reg[k-1];
            end
            bit_k = 64'd1 << (62 - 2 * k);
            trial = r_in[k] + bit_k;
            if (v_in[k] >= trial)
            begin
                v_next[k] = v_in[k] - trial;
                r_next[k] = (r_in[k] >> 1) + bit_k;
            end
            else
            begin
                v_next[k] = v_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = r_reg[N-1][31:0];
    assign out_side  = side_reg[N-1];

endmodule

>>> rtl/core/gps_div.sv
// Two-lane pipelined restoring divider: quo = floor(num * 2^30 / den), num <= den.
module gps_div (
    input  logic            clk,
    input  logic            en,
    input  logic [1:0][31:0] num,
    input  logic [31:0]     den,
    output logic [1:0][30:0] quo
);

    localparam int N = gps_pkg::DIV_STAGES;

    logic [32:0]      rem_reg [2][N];
    logic [30:0]      q_reg   [2][N];
    logic [31:0]      den_reg [N];

    logic [32:0]      rem_next [2][N];
    logic [30:0]      q_next   [2][N];
    logic [31:0]      den_in   [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            den_in[k] = (k == 0) ? den : den_reg[k-1];
        end
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < N; k++)
            begin
                logic [32:0] rem_in;
                logic [30:0] q_in;
                logic [32:0] diff;
                logic        ge;
                rem_in = (k == 0) ? {1'b0, num[l]} : rem_reg[l][k-1];
                q_in   = (k == 0) ? '0 : q_reg[l][k-1];
                ge     = rem_in >= {1'b0, den_in[k]};
                diff   = ge ? (rem_in - {1'b0, den_in[k]}) : rem_in;
                rem_next[l][k] = {diff[31:0], 1'b0};
                q_next[l][k]   = {q_in[29:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                den_reg[k] <= den_in[k];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l][k] <= rem_next[l][k];
                    q_reg[l][k]   <= q_next[l][k];
                end
            end
        end
    end

    assign quo[0] = q_reg[0][N-1];
    assign quo[1] = q_reg[1][N-1];

endmodule

>>> rtl/core/gaussian_polar_sampler.sv
// Marsaglia polar Gaussian sampler, fixed-point, fully pipelined top level.
//
// Each input transaction carries two uniform draws. They are mapped to
// x in [-1,1) and w = x1^2 + x2^2 is formed; pairs with w = 0 or w >= 1 are
// dropped and produce no output. Accepted pairs produce two output
// transactions, mean + x1*f*scale then mean + x2*f*scale with last = 1 on the
// second, where f = sqrt(-2 ln w / w). Samples are signed Q4.27 and saturate.
// The pipeline is 77 stages deep (front end 6, squaring log and normalizing
// root 32 in parallel, ln/scale 3, result root and divide 32 in parallel,
// output math 4), followed by a pair buffer. A new pair can enter every cycle
// unless a kept pair sits at the last stage while the pair buffer is still
// busy; the output port moves one sample per cycle while sample_ready is
// high, so with a steady stream of kept pairs the block takes a new input
// only as the second sample of the buffered pair leaves.
// All stages advance together on one enable, so back-pressure never drops
// or repeats a transaction. mean_offset and scale_factor are sampled at the
// back end and must only be written while the block is idle.
module gaussian_polar_sampler #(
    parameter int UNIFORM_BITS = 32,
    parameter int FRAC_BITS    = 27
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transactions
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [31:0]        uniform_first,
    input  logic [31:0]        uniform_second,
    // configuration writes
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // output transactions
    output logic               sample_valid,
    input  logic               sample_ready,
    output logic signed [31:0] sample,
    output logic               last
);

    // Draw alignment to a 32-bit fraction.
    localparam int SHR = (UNIFORM_BITS > 32) ? (UNIFORM_BITS - 32) : 0;
    localparam int SHL = (UNIFORM_BITS < 32) ? (32 - UNIFORM_BITS) : 0;

    // Reset scale is 1.0, clamped to the register range.
    localparam logic [30:0] SCALE_RESET =
        (FRAC_BITS >= 31) ? 31'h7FFF_FFFF : 31'(64'd1 << FRAC_BITS);

    function automatic logic [3:0] msb16(input logic [15:0] v);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] res;
        if (v > 38'sd2147483647)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (v < -38'sd2147483648)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] mean_offset_reg;
    logic [30:0]        scale_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_offset_reg  <= '0;
            scale_factor_reg <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gps_pkg::REG_MEAN_OFFSET:  mean_offset_reg  <= cfg_data;
                gps_pkg::REG_SCALE_FACTOR: scale_factor_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the whole pipe moves when the last stage holds no
    // kept pair, or the pair buffer can take a new pair (empty, or its
    // second sample leaves this cycle).
    // ------------------------------------------------------------------
    logic pend_valid_reg;
    logic pend_phase_reg;
    logic adv;
    logic f4_valid_reg;

    assign adv        = !pend_valid_reg || (pend_phase_reg && sample_ready) || !f4_valid_reg;
    assign item_ready = adv;

    // ------------------------------------------------------------------
    // S1: signed coordinates as magnitude + sign
    // ------------------------------------------------------------------
    logic [31:0] u1, u2;
    logic        neg1, neg2;
    logic [31:0] ax1, ax2;

    assign u1   = (uniform_first  >> SHR) << SHL;
    assign u2   = (uniform_second >> SHR) << SHL;
    assign neg1 = ~u1[31];
    assign neg2 = ~u2[31];
    assign ax1  = neg1 ? (32'h8000_0000 - u1) : {1'b0, u1[30:0]};
    assign ax2  = neg2 ? (32'h8000_0000 - u2) : {1'b0, u2[30:0]};

    logic        s1_valid_reg;
    logic [31:0] s1_ax1_reg, s1_ax2_reg;
    logic        s1_neg1_reg, s1_neg2_reg;

    // S2: squares
    logic        s2_valid_reg;
    logic [63:0] s2_sq1_reg, s2_sq2_reg;
    logic [31:0] s2_ax1_reg, s2_ax2_reg;
    logic        s2_neg1_reg, s2_neg2_reg;

    // S3: w and rejection
    logic [63:0] s3_sum;
    logic        s3_keep;
    logic        s3_valid_reg;
    logic [61:0] s3_s_reg;
    logic [31:0] s3_ax1_reg, s3_ax2_reg;
    logic        s3_neg1_reg, s3_neg2_reg;

    assign s3_sum  = s2_sq1_reg + s2_sq2_reg;
    assign s3_keep = (s3_sum != 64'd0) && (s3_sum[63:62] == 2'b00);

    // S4: leading-one search per 16-bit chunk
    logic [63:0] s4_word;
    logic        s4_valid_reg;
    logic [3:0]  s4_nz_reg;
    logic [3:0]  s4_idx_reg [4];
    logic [61:0] s4_s_reg;
    logic [31:0] s4_ax1_reg, s4_ax2_reg;
    logic        s4_neg1_reg, s4_neg2_reg;

    assign s4_word = {2'b00, s3_s_reg};

    // S5: leading-one position p
    logic [5:0]  s5_p;
    logic        s5_valid_reg;
    logic [5:0]  s5_p_reg;
    logic [61:0] s5_s_reg;
    logic [31:0] s5_ax1_reg, s5_ax2_reg;
    logic        s5_neg1_reg, s5_neg2_reg;

    always_comb
    begin
        if (s4_nz_reg[3])
        begin
            s5_p = {2'd3, s4_idx_reg[3]};
        end
        else if (s4_nz_reg[2])
        begin
            s5_p = {2'd2, s4_idx_reg[2]};
        end
        else if (s4_nz_reg[1])
        begin
            s5_p = {2'd1, s4_idx_reg[1]};
        end
        else
        begin
            s5_p = {2'd0, s4_idx_reg[0]};
        end
    end

    // S6: normalize; log mantissa and even-shifted radicand
    logic [63:0] s6_sn;
    logic        s6_valid_reg;
    logic [31:0] s6_y_reg;
    logic [63:0] s6_s2e_reg;
    logic [5:0]  s6_p_reg;
    logic [31:0] s6_ax1_reg, s6_ax2_reg;
    logic        s6_neg1_reg, s6_neg2_reg;

    assign s6_sn = {2'b00, s5_s_reg} << (6'd63 - s5_p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s3_keep;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ax1_reg  <= ax1;
            s1_ax2_reg  <= ax2;
            s1_neg1_reg <= neg1;
            s1_neg2_reg <= neg2;

            s2_sq1_reg  <= s1_ax1_reg * s1_ax1_reg;
            s2_sq2_reg  <= s1_ax2_reg * s1_ax2_reg;
            s2_ax1_reg  <= s1_ax1_reg;
            s2_ax2_reg  <= s1_ax2_reg;
            s2_neg1_reg <= s1_neg1_reg;
            s2_neg2_reg <= s1_neg2_reg;

            s3_s_reg    <= s3_sum[61:0];
            s3_ax1_reg  <= s2_ax1_reg;
            s3_ax2_reg  <= s2_ax2_reg;
            s3_neg1_reg <= s2_neg1_reg;
            s3_neg2_reg <= s2_neg2_reg;

            for (int c = 0; c < 4; c++)
            begin
                s4_nz_reg[c]  <= (s4_word[c*16 +: 16] != 16'd0);
                s4_idx_reg[c] <= msb16(s4_word[c*16 +: 16]);
            end
            s4_s_reg    <= s3_s_reg;
            s4_ax1_reg  <= s3_ax1_reg;
            s4_ax2_reg  <= s3_ax2_reg;
            s4_neg1_reg <= s3_neg1_reg;
            s4_neg2_reg <= s3_neg2_reg;

            s5_p_reg    <= s5_p;
            s5_s_reg    <= s4_s_reg;
            s5_ax1_reg  <= s4_ax1_reg;
            s5_ax2_reg  <= s4_ax2_reg;
            s5_neg1_reg <= s4_neg1_reg;
            s5_neg2_reg <= s4_neg2_reg;

            // top word has its leading one at bit 31; p odd means 63-p is already even
            s6_y_reg    <= s6_sn[63:32];
            s6_s2e_reg  <= s5_p_reg[0] ? s6_sn : (s6_sn >> 1);
            s6_p_reg    <= s5_p_reg;
            s6_ax1_reg  <= s5_ax1_reg;
            s6_ax2_reg  <= s5_ax2_reg;
            s6_neg1_reg <= s5_neg1_reg;
            s6_neg2_reg <= s5_neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // B: fraction of log2 of the mantissa of w by repeated squaring, one bit per stage,
    // alongside isqrt of the normalized w (same depth).
    // ------------------------------------------------------------------
    localparam int LN = gps_pkg::LOG_STAGES;

    logic [31:0] log_y_reg [LN];
    logic [31:0] log_f_reg [LN];
    logic [31:0] log_y_in  [LN];
    logic [31:0] log_f_in  [LN];
    logic [63:0] log_sq    [LN];
    logic [32:0] log_y2    [LN];

    always_comb
    begin
        for (int k = 0; k < LN; k++)
        begin
            if (k == 0)
            begin
                log_y_in[k] = s6_y_reg;
                log_f_in[k] = '0;
            end
            else
            begin
                log_y_in[k] = log_y_reg[k-1];
                log_f_in[k] = log_f_reg[k-1];
            end
            log_sq[k] = log_y_in[k] * log_y_in[k];
            log_y2[k] = log_sq[k][63:31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LN; k++)
            begin
                log_y_reg[k] <= log_y2[k][32] ? log_y2[k][32:1] : log_y2[k][31:0];
                log_f_reg[k] <= {log_f_in[k][30:0], log_y2[k][32]};
            end
        end
    end

    localparam int NSIDE_W = 2 + 32 + 32 + 6;

    logic               b_valid;
    logic [31:0]        b_isq;
    logic [NSIDE_W-1:0] b_side;

    gps_isqrt #(
        .SIDE_W (NSIDE_W)
    ) u_isq_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s6_valid_reg),
        .in_value  (s6_s2e_reg),
        .in_side   ({s6_neg1_reg, s6_neg2_reg, s6_ax1_reg, s6_ax2_reg, s6_p_reg}),
        .out_valid (b_valid),
        .out_root  (b_isq),
        .out_side  (b_side)
    );

    logic        b_neg1, b_neg2;
    logic [31:0] b_ax1, b_ax2;
    logic [5:0]  b_p;

    assign b_neg1 = b_side[71];
    assign b_neg2 = b_side[70];
    assign b_ax1  = b_side[69:38];
    assign b_ax2  = b_side[37:6];
    assign b_p    = b_side[5:0];

    // ------------------------------------------------------------------
    // C0..C2: numerators |x| << e, -log2 w, then L = -2 ln w
    // ------------------------------------------------------------------
    logic [5:0]  c0_e6;
    logic [4:0]  c0_e;
    logic [63:0] c0_a1_wide, c0_a2_wide;
    logic [37:0] c0_lg;

    assign c0_e6      = (6'd63 - b_p) >> 1;
    assign c0_e       = c0_e6[4:0];
    assign c0_a1_wide = {32'd0, b_ax1} << c0_e;
    assign c0_a2_wide = {32'd0, b_ax2} << c0_e;
    assign c0_lg      = {6'd62 - b_p, 32'd0} - {6'd0, log_f_reg[LN-1]};

    logic        c0_valid_reg, c1_valid_reg, c2_valid_reg;
    logic [31:0] c0_a1_reg, c0_a2_reg, c0_isq_reg;
    logic        c0_neg1_reg, c0_neg2_reg;
    logic [37:0] c0_lg_reg;

    logic [37:0] c1_m1;
    logic [63:0] c1_m2_wide;
    logic [37:0] c1_m1_reg;
    logic [31:0] c1_m2_reg;
    logic [31:0] c1_a1_reg, c1_a2_reg, c1_isq_reg;
    logic        c1_neg1_reg, c1_neg2_reg;

    assign c1_m1      = 38'(c0_lg_reg[37:32]) * 38'(gps_pkg::LN2_Q32);
    assign c1_m2_wide = 64'(c0_lg_reg[31:0]) * 64'(gps_pkg::LN2_Q32);

    logic [38:0] c2_lsum;
    logic [39:0] c2_l_reg;
    logic [31:0] c2_a1_reg, c2_a2_reg, c2_isq_reg;
    logic        c2_neg1_reg, c2_neg2_reg;

    assign c2_lsum = {1'b0, c1_m1_reg} + {7'd0, c1_m2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c0_valid_reg <= b_valid;
            c1_valid_reg <= c0_valid_reg;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // |x| << e never exceeds the root of the normalized w, so it fits 32 bits
            c0_a1_reg   <= c0_a1_wide[31:0];
            c0_a2_reg   <= c0_a2_wide[31:0];
            c0_isq_reg  <= b_isq;
            c0_neg1_reg <= b_neg1;
            c0_neg2_reg <= b_neg2;
            c0_lg_reg   <= c0_lg;

            c1_m1_reg   <= c1_m1;
            c1_m2_reg   <= c1_m2_wide[63:32];
            c1_a1_reg   <= c0_a1_reg;
            c1_a2_reg   <= c0_a2_reg;
            c1_isq_reg  <= c0_isq_reg;
            c1_neg1_reg <= c0_neg1_reg;
            c1_neg2_reg <= c0_neg2_reg;

            c2_l_reg    <= {c2_lsum, 1'b0};
            c2_a1_reg   <= c1_a1_reg;
            c2_a2_reg   <= c1_a2_reg;
            c2_isq_reg  <= c1_isq_reg;
            c2_neg1_reg <= c1_neg1_reg;
            c2_neg2_reg <= c1_neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // D: r = sqrt(L) in Q4.28 and c = |x|/sqrt(w) in Q.30, in parallel.
    // The divider is one stage shorter; a register evens them up.
    // ------------------------------------------------------------------
    logic        d_valid;
    logic [31:0] d_root;
    logic [1:0]  d_side;

    gps_isqrt #(
        .SIDE_W (2)
    ) u_isq_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c2_valid_reg),
        .in_value  ({c2_l_reg, 24'd0}),
        .in_side   ({c2_neg1_reg, c2_neg2_reg}),
        .out_valid (d_valid),
        .out_root  (d_root),
        .out_side  (d_side)
    );

    logic [1:0][30:0] div_quo;
    logic [30:0]      dq1_reg, dq2_reg;

    gps_div u_div (
        .clk (clk),
        .en  (adv),
        .num ({c2_a2_reg, c2_a1_reg}),
        .den (c2_isq_reg),
        .quo (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dq1_reg <= div_quo[0];
            dq2_reg <= div_quo[1];
        end
    end

    // ------------------------------------------------------------------
    // F1..F4: z = c*r, scale, round half up, sign, offset
    // ------------------------------------------------------------------
    logic [62:0] f1_zp1, f1_zp2;
    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [31:0] f1_z1_reg, f1_z2_reg;
    logic        f1_neg1_reg, f1_neg2_reg;

    assign f1_zp1 = 63'(dq1_reg) * 63'(d_root);
    assign f1_zp2 = 63'(dq2_reg) * 63'(d_root);

    logic [62:0] f2_p1_reg, f2_p2_reg;
    logic        f2_neg1_reg, f2_neg2_reg;

    logic [63:0] f3_rnd1, f3_rnd2;
    logic [35:0] f3_mag1_reg, f3_mag2_reg;
    logic        f3_neg1_reg, f3_neg2_reg;

    assign f3_rnd1 = {1'b0, f2_p1_reg} + 64'h0000_0000_0800_0000;
    assign f3_rnd2 = {1'b0, f2_p2_reg} + 64'h0000_0000_0800_0000;

    logic signed [37:0] f4_mean;
    logic signed [37:0] f4_mag1, f4_mag2;
    logic signed [37:0] f4_v1_reg, f4_v2_reg;

    assign f4_mean = {{6{mean_offset_reg[31]}}, mean_offset_reg};
    assign f4_mag1 = {2'b00, f3_mag1_reg};
    assign f4_mag2 = {2'b00, f3_mag2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= d_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_z1_reg   <= f1_zp1[61:30];
            f1_z2_reg   <= f1_zp2[61:30];
            f1_neg1_reg <= d_side[1];
            f1_neg2_reg <= d_side[0];

            f2_p1_reg   <= 63'(f1_z1_reg) * 63'(scale_factor_reg);
            f2_p2_reg   <= 63'(f1_z2_reg) * 63'(scale_factor_reg);
            f2_neg1_reg <= f1_neg1_reg;
            f2_neg2_reg <= f1_neg2_reg;

            f3_mag1_reg <= f3_rnd1[63:28];
            f3_mag2_reg <= f3_rnd2[63:28];
            f3_neg1_reg <= f2_neg1_reg;
            f3_neg2_reg <= f2_neg2_reg;

            f4_v1_reg   <= f3_neg1_reg ? (f4_mean - f4_mag1) : (f4_mean + f4_mag1);
            f4_v2_reg   <= f3_neg2_reg ? (f4_mean - f4_mag2) : (f4_mean + f4_mag2);
        end
    end

    // ------------------------------------------------------------------
    // Pair buffer: holds both samples of a kept pair, sends first then last.
    // ------------------------------------------------------------------
    logic        pend_valid_next;
    logic        pend_phase_next;
    logic [31:0] pend_a_reg, pend_b_reg;
    logic        pend_load;

    assign pend_load = adv && f4_valid_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_phase_next = pend_phase_reg;
        if (pend_load)
        begin
            pend_valid_next = 1'b1;
            pend_phase_next = 1'b0;
        end
        else if (pend_valid_reg && sample_ready)
        begin
            if (pend_phase_reg)
            begin
                pend_valid_next = 1'b0;
                pend_phase_next = 1'b0;
            end
            else
            begin
                pend_phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_phase_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_phase_reg <= pend_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_a_reg <= sat32(f4_v1_reg);
            pend_b_reg <= sat32(f4_v2_reg);
        end
    end

    assign sample_valid = pend_valid_reg;
    assign sample       = pend_phase_reg ? pend_b_reg : pend_a_reg;
    assign last         = pend_phase_reg;

endmodule
